/* rtl/drd_pkg.sv */
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the detection row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int VALUE_W  = 24;   // element value, signed fixed point
    localparam int SCALE_W  = 16;   // x/y scale, unsigned Q4.12
    localparam int THR_W    = 13;   // score threshold
    localparam int FRAME_W  = 13;   // frame size in pixels
    localparam int CFG_W    = 16;   // config write data
    localparam int CFG_IDX_W = 3;
    localparam int CLASS_W  = 8;
    localparam int SCORE_W  = 23;
    localparam int EDGE_W   = 12;   // box left / top
    localparam int EXT_W    = 13;   // box width / height

    // 2*center - extent needs two extra bits
    localparam int DX_W   = VALUE_W + 2;
    // signed DX_W times zero-extended scale
    localparam int PROD_W = DX_W + SCALE_W + 1;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 13'd4096;

    // element positions inside a row
    localparam int POS_CX          = 0;
    localparam int POS_CY          = 1;
    localparam int POS_W           = 2;
    localparam int POS_H           = 3;
    localparam int POS_FIRST_SCORE = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THR = 3'd0,
        CFG_X_SCALE   = 3'd1,
        CFG_Y_SCALE   = 3'd2,
        CFG_FRAME_W   = 3'd3,
        CFG_FRAME_H   = 3'd4
    } t_cfg_index;

    // row summary handed from the accumulator to the scaler
    typedef struct packed {
        logic signed [DX_W-1:0]    dx;     // 2*cx - w
        logic signed [DX_W-1:0]    dy;     // 2*cy - h
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] h;
        logic [CLASS_W-1:0]        class_idx;
        logic [SCORE_W-1:0]        score;
    } t_row_snap;

    // scaling / clamping settings
    typedef struct packed {
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] y_scale;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
    } t_scale_cfg;

endpackage

/* rtl/drd_if.sv */
// ----------------------------------------------------------------------------
// drd_if
// Stream interfaces: row elements in, decoded boxes out.
// ----------------------------------------------------------------------------
interface drd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [drd_pkg::VALUE_W-1:0]  element_value;
    logic                                row_last;

    modport source(output valid, output element_value, output row_last, input ready);
    modport sink(input valid, input element_value, input row_last, output ready);
endinterface

interface drd_out_if;
    logic                           valid;
    logic                           ready;
    logic [drd_pkg::EDGE_W-1:0]     box_left;
    logic [drd_pkg::EDGE_W-1:0]     box_top;
    logic [drd_pkg::EXT_W-1:0]      box_width;
    logic [drd_pkg::EXT_W-1:0]      box_height;
    logic [drd_pkg::CLASS_W-1:0]    class_index;
    logic [drd_pkg::SCORE_W-1:0]    best_score;

    modport source(output valid, output box_left, output box_top, output box_width,
                   output box_height, output class_index, output best_score,
                   input ready);
    modport sink(input valid, input box_left, input box_top, input box_width,
                 input box_height, input class_index, input best_score,
                 output ready);
endinterface

/* rtl/drd_row_acc.sv */
// ----------------------------------------------------------------------------
// drd_row_acc
// Per-row box capture and running argmax; registers one row summary at row end.
// ----------------------------------------------------------------------------
module drd_row_acc #(
    parameter int MAX_ROW_LENGTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    drd_in_if.sink                       i_elem,
    input  logic [drd_pkg::THR_W-1:0]    i_score_thr,
    output logic                         o_snap_valid,
    input  logic                         i_snap_ready,
    output drd_pkg::t_row_snap           o_snap
);

    localparam int IW  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CLW = (IW > drd_pkg::CLASS_W) ? IW : drd_pkg::CLASS_W;
    localparam int VW  = drd_pkg::VALUE_W;
    localparam int DW  = drd_pkg::DX_W;

    logic [IW-1:0]           r_idx, n_idx;
    logic signed [VW-1:0]    r_cx, r_cy, r_w, r_h, n_cx, n_cy, n_w, n_h;
    logic signed [VW-1:0]    r_best, n_best;
    logic [drd_pkg::CLASS_W-1:0] r_class, n_class;
    logic                    r_snap_v;
    drd_pkg::t_row_snap      r_snap;

    logic                    accept;
    logic                    in_range;
    logic                    take_score;
    logic [CLW-1:0]          class_full;
    logic                    emit;

    assign i_elem.ready = !r_snap_v || i_snap_ready;
    assign accept       = i_elem.valid && i_elem.ready;
    assign in_range     = r_idx < IW'(MAX_ROW_LENGTH);
    assign class_full   = CLW'(r_idx) - CLW'(drd_pkg::POS_FIRST_SCORE);

    // first score always wins, later ones only when strictly larger
    assign take_score = in_range && (r_idx >= IW'(drd_pkg::POS_FIRST_SCORE)) &&
                        ((r_idx == IW'(drd_pkg::POS_FIRST_SCORE)) ||
                         (i_elem.element_value > r_best));

    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_best  = r_best;
        n_class = r_class;
        n_idx   = in_range ? r_idx + IW'(1) : r_idx;
        if (in_range && r_idx == IW'(drd_pkg::POS_CX)) begin
            n_cx = i_elem.element_value;
        end
        if (in_range && r_idx == IW'(drd_pkg::POS_CY)) begin
            n_cy = i_elem.element_value;
        end
        if (in_range && r_idx == IW'(drd_pkg::POS_W)) begin
            n_w = i_elem.element_value;
        end
        if (in_range && r_idx == IW'(drd_pkg::POS_H)) begin
            n_h = i_elem.element_value;
        end
        if (take_score) begin
            n_best  = i_elem.element_value;
            n_class = class_full[drd_pkg::CLASS_W-1:0];
        end
    end

    // five or more elements seen <=> at least one score taken; threshold >= 0
    // so the compare also rejects negative scores
    assign emit = i_elem.row_last && (r_idx >= IW'(drd_pkg::POS_FIRST_SCORE)) &&
                  (n_best >= $signed({{(VW-drd_pkg::THR_W){1'b0}}, i_score_thr}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_snap_v <= 1'b0;
        end else begin
            if (accept) begin
                r_idx <= i_elem.row_last ? '0 : n_idx;
            end
            if (accept && emit) begin
                r_snap_v <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_w     <= n_w;
            r_h     <= n_h;
            r_best  <= n_best;
            r_class <= n_class;
        end
        if (accept && emit) begin
            r_snap.dx        <= (DW'(r_cx) <<< 1) - DW'(r_w);
            r_snap.dy        <= (DW'(r_cy) <<< 1) - DW'(r_h);
            r_snap.w         <= r_w;
            r_snap.h         <= r_h;
            r_snap.class_idx <= n_class;
            r_snap.score     <= n_best[drd_pkg::SCORE_W-1:0];
        end
    end

    assign o_snap_valid = r_snap_v;
    assign o_snap       = r_snap;

endmodule

/* rtl/drd_box_scale.sv */
// ----------------------------------------------------------------------------
// drd_box_scale
// Three-stage box scaler: multiply, truncating shift, clamp to frame.
// ----------------------------------------------------------------------------
module drd_box_scale #(
    parameter int VALUE_FRAC_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_snap_valid,
    output logic                   o_snap_ready,
    input  drd_pkg::t_row_snap     i_snap,
    input  drd_pkg::t_scale_cfg    i_cfg,
    drd_out_if.source              o_box
);

    localparam int PW   = drd_pkg::PROD_W;
    localparam int SH_H = VALUE_FRAC_BITS + 13;  // edge: also halves 2*center
    localparam int SH_F = VALUE_FRAC_BITS + 12;
    localparam int QW   = PW - SH_F;
    localparam int CW   = ((QW > drd_pkg::FRAME_W + 1) ? QW : drd_pkg::FRAME_W + 1) + 1;

    // arithmetic shift right, truncating toward zero
    function automatic logic signed [CW-1:0] trunc_shift(
        input logic signed [PW-1:0] p,
        input int                   sh
    );
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] q;
        bias = p[PW-1] ? ((PW'(1) <<< sh) - PW'(1)) : '0;
        q    = (p + bias) >>> sh;
        return q[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] clamp_pos(
        input logic signed [CW-1:0] pos,
        input logic signed [CW-1:0] lim
    );
        logic signed [CW-1:0] p;
        p = (pos > lim - CW'(1)) ? lim - CW'(1) : pos;
        return (p < 0) ? '0 : p;
    endfunction

    function automatic logic signed [CW-1:0] clamp_ext(
        input logic signed [CW-1:0] ext,
        input logic signed [CW-1:0] pos,
        input logic signed [CW-1:0] lim
    );
        logic signed [CW-1:0] e;
        e = (ext > lim - pos) ? lim - pos : ext;
        return (e < 0) ? '0 : e;
    endfunction

    logic                          en2, en3, en4;
    logic                          r_v2, r_v3, r_v4;
    logic signed [PW-1:0]          r_px, r_py, r_pw, r_ph;
    logic signed [CW-1:0]          r_qx, r_qy, r_qw, r_qh;
    logic [drd_pkg::CLASS_W-1:0]   r_cls2, r_cls3, r_cls4;
    logic [drd_pkg::SCORE_W-1:0]   r_scr2, r_scr3, r_scr4;
    logic [drd_pkg::EDGE_W-1:0]    r_left, r_top;
    logic [drd_pkg::EXT_W-1:0]     r_wid, r_hei;

    logic signed [drd_pkg::SCALE_W:0] xs, ys;
    logic [drd_pkg::FRAME_W-1:0]   fw, fh;
    logic signed [CW-1:0]          lim_x, lim_y, cx_pos, cy_pos, cx_ext, cy_ext;

    assign en4          = !r_v4 || o_box.ready;
    assign en3          = !r_v3 || en4;
    assign en2          = !r_v2 || en3;
    assign o_snap_ready = en2;

    assign xs = $signed({1'b0, i_cfg.x_scale});
    assign ys = $signed({1'b0, i_cfg.y_scale});

    assign fw = (i_cfg.frame_w > drd_pkg::FRAME_MAX) ? drd_pkg::FRAME_MAX : i_cfg.frame_w;
    assign fh = (i_cfg.frame_h > drd_pkg::FRAME_MAX) ? drd_pkg::FRAME_MAX : i_cfg.frame_h;
    assign lim_x = CW'($signed({1'b0, fw}));
    assign lim_y = CW'($signed({1'b0, fh}));

    assign cx_pos = clamp_pos(r_qx, lim_x);
    assign cy_pos = clamp_pos(r_qy, lim_y);
    assign cx_ext = clamp_ext(r_qw, cx_pos, lim_x);
    assign cy_ext = clamp_ext(r_qh, cy_pos, lim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_snap_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_snap_valid) begin
            r_px   <= PW'(i_snap.dx) * PW'(xs);
            r_py   <= PW'(i_snap.dy) * PW'(ys);
            r_pw   <= PW'(i_snap.w) * PW'(xs);
            r_ph   <= PW'(i_snap.h) * PW'(ys);
            r_cls2 <= i_snap.class_idx;
            r_scr2 <= i_snap.score;
        end
        if (en3 && r_v2) begin
            r_qx   <= trunc_shift(r_px, SH_H);
            r_qy   <= trunc_shift(r_py, SH_H);
            r_qw   <= trunc_shift(r_pw, SH_F);
            r_qh   <= trunc_shift(r_ph, SH_F);
            r_cls3 <= r_cls2;
            r_scr3 <= r_scr2;
        end
        if (en4 && r_v3) begin
            r_left <= cx_pos[drd_pkg::EDGE_W-1:0];
            r_top  <= cy_pos[drd_pkg::EDGE_W-1:0];
            r_wid  <= cx_ext[drd_pkg::EXT_W-1:0];
            r_hei  <= cy_ext[drd_pkg::EXT_W-1:0];
            r_cls4 <= r_cls3;
            r_scr4 <= r_scr3;
        end
    end

    assign o_box.valid       = r_v4;
    assign o_box.box_left    = r_left;
    assign o_box.box_top     = r_top;
    assign o_box.box_width   = r_wid;
    assign o_box.box_height  = r_hei;
    assign o_box.class_index = r_cls4;
    assign o_box.best_score  = r_scr4;

endmodule

/* rtl/detection_row_decode_top.sv */
// ----------------------------------------------------------------------------
// detection_row_decode_top
// Decodes detector rows (box + class scores) into one clamped frame box.
// ----------------------------------------------------------------------------
// Usage:
//   i_elem carries one row element per request (Q12.12 value plus row_last).
//   Elements 0..3 are center x, center y, width, height; the rest are class
//   scores. o_box carries at most one request per row: the scaled, clamped
//   box, the argmax class (lowest index on ties) and its score.
//   Throughput: one element per cycle, sustained while o_box is not held
//   off; the row accumulator is registered and the scaler is a three-stage
//   pipeline. After the row_last element is taken, the box for a row goes
//   through the row summary register, then the multiply, shift and clamp stages.
//   Rows shorter than five elements, or whose best score is below the
//   threshold, produce nothing. Elements past MAX_ROW_LENGTH are dropped.
//   Stall: when o_box is held off, the pipeline fills and i_elem.ready drops
//   only once the row summary register is occupied and cannot advance.
//   Reset (i_rst_n low, synchronous): row state and pipeline are emptied and
//   the registers return to threshold 0.45, scales 1.0, frame 640x640.
//   Users write i_cfg_* registers only while no row is in flight; unchecked.
// ----------------------------------------------------------------------------
module detection_row_decode_top #(
    parameter int MAX_ROW_LENGTH  = 256,
    parameter int VALUE_FRAC_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    drd_in_if.sink                           i_elem,
    drd_out_if.source                        o_box,
    input  logic                             i_cfg_wr_en,
    input  logic [drd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drd_pkg::CFG_W-1:0]        i_cfg_data
);

    // configuration registers
    logic [drd_pkg::THR_W-1:0]   r_score_thr;
    logic [drd_pkg::SCALE_W-1:0] r_x_scale;
    logic [drd_pkg::SCALE_W-1:0] r_y_scale;
    logic [drd_pkg::FRAME_W-1:0] r_frame_w;
    logic [drd_pkg::FRAME_W-1:0] r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr <= 13'd1843;     // 0.45 in Q12.12
            r_x_scale   <= 16'd4096;     // 1.0 in Q4.12
            r_y_scale   <= 16'd4096;
            r_frame_w   <= 13'd640;
            r_frame_h   <= 13'd640;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                drd_pkg::CFG_SCORE_THR: begin
                    r_score_thr <= i_cfg_data[drd_pkg::THR_W-1:0];
                end
                drd_pkg::CFG_X_SCALE: begin
                    r_x_scale <= i_cfg_data[drd_pkg::SCALE_W-1:0];
                end
                drd_pkg::CFG_Y_SCALE: begin
                    r_y_scale <= i_cfg_data[drd_pkg::SCALE_W-1:0];
                end
                drd_pkg::CFG_FRAME_W: begin
                    r_frame_w <= i_cfg_data[drd_pkg::FRAME_W-1:0];
                end
                drd_pkg::CFG_FRAME_H: begin
                    r_frame_h <= i_cfg_data[drd_pkg::FRAME_W-1:0];
                end
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    // row summary between accumulator and scaler
    logic                  snap_valid;
    logic                  snap_ready;
    drd_pkg::t_row_snap    snap;
    drd_pkg::t_scale_cfg   scale_cfg;

    assign scale_cfg.x_scale = r_x_scale;
    assign scale_cfg.y_scale = r_y_scale;
    assign scale_cfg.frame_w = r_frame_w;
    assign scale_cfg.frame_h = r_frame_h;

    drd_row_acc #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_row_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem       (i_elem),
        .i_score_thr  (r_score_thr),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    drd_box_scale #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_box_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .i_cfg        (scale_cfg),
        .o_box        (o_box)
    );

    // effective frame limits for the checks below
    logic [drd_pkg::FRAME_W-1:0] chk_fw, chk_fh;
    assign chk_fw = (r_frame_w > drd_pkg::FRAME_MAX) ? drd_pkg::FRAME_MAX : r_frame_w;
    assign chk_fh = (r_frame_h > drd_pkg::FRAME_MAX) ? drd_pkg::FRAME_MAX : r_frame_h;

    // box stays inside the frame horizontally
    a_box_in_frame_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> ({2'b0, o_box.box_left} + {1'b0, o_box.box_width}) <= {1'b0, chk_fw})
        else $error("box exceeds frame width");

    // box stays inside the frame vertically
    a_box_in_frame_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> ({2'b0, o_box.box_top} + {1'b0, o_box.box_height}) <= {1'b0, chk_fh})
        else $error("box exceeds frame height");

    // only rows that pass the score threshold come out
    a_score_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> o_box.best_score >= {{(drd_pkg::SCORE_W-drd_pkg::THR_W){1'b0}}, r_score_thr})
        else $error("result below score threshold");

endmodule

/* test/detection_row_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_row_checker
// Watches the element and box channels and the register port, rebuilds the
// row decode (argmax, scaling, clamping) and compares every box in order.
// ----------------------------------------------------------------------------
module detection_row_checker #(
    parameter int MAX_ROW = 256,
    parameter int FRAC    = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    drd_in_if                             i_elem,
    drd_out_if                            i_box,
    input  logic                          i_cfg_wr_en,
    input  logic [drd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drd_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_boxes_pending,
    output int                            o_boxes_checked,
    output int                            o_rows_done
);

    typedef struct packed {
        logic [drd_pkg::EDGE_W-1:0]  left;
        logic [drd_pkg::EDGE_W-1:0]  top;
        logic [drd_pkg::EXT_W-1:0]   width;
        logic [drd_pkg::EXT_W-1:0]   height;
        logic [drd_pkg::CLASS_W-1:0] class_idx;
        logic [drd_pkg::SCORE_W-1:0] score;
    } t_det_box;

    // register values after reset
    localparam logic [drd_pkg::THR_W-1:0]   RST_THR   = 13'd1843;
    localparam logic [drd_pkg::SCALE_W-1:0] RST_SCALE = 16'd4096;
    localparam logic [drd_pkg::FRAME_W-1:0] RST_FRAME = 13'd640;

    logic [drd_pkg::THR_W-1:0]   thr;
    logic [drd_pkg::SCALE_W-1:0] x_scl;
    logic [drd_pkg::SCALE_W-1:0] y_scl;
    logic [drd_pkg::FRAME_W-1:0] frame_w;
    logic [drd_pkg::FRAME_W-1:0] frame_h;

    int     elem_count;
    longint row_cx;
    longint row_cy;
    longint row_w;
    longint row_h;
    longint best_score;
    int     best_class;

    t_det_box pending_boxes[$];

    int fail_count    = 0;
    int boxes_pending = 0;
    int boxes_checked = 0;
    int rows_done     = 0;

    assign o_fail_count    = fail_count;
    assign o_boxes_pending = boxes_pending;
    assign o_boxes_checked = boxes_checked;
    assign o_rows_done     = rows_done;

    function automatic void clear_row();
        elem_count = 0;
        row_cx     = 0;
        row_cy     = 0;
        row_w      = 0;
        row_h      = 0;
        best_score = 0;
        best_class = 0;
    endfunction

    // arithmetic shift with rounding toward zero
    function automatic longint shr_toward_zero(input longint p, input int sh);
        if (p < 0) return -((-p) >>> sh);
        return p >>> sh;
    endfunction

    function automatic void clamp_span(input longint pos, input longint ext, input longint lim,
                                       output longint opos, output longint oext);
        opos = pos;
        oext = ext;
        if (opos > lim - 1) opos = lim - 1;
        if (opos < 0) opos = 0;
        if (oext > lim - opos) oext = lim - opos;
        if (oext < 0) oext = 0;
    endfunction

    function automatic string box_text(input t_det_box b);
        return $sformatf("l=%0d t=%0d w=%0d h=%0d cls=%0d score=%0d",
                         b.left, b.top, b.width, b.height, b.class_idx, b.score);
    endfunction

    // one accepted element: update the row, predict a box on row end
    function automatic void take_element(input logic signed [drd_pkg::VALUE_W-1:0] value,
                                         input logic last);
        longint   v;
        longint   lim_w;
        longint   lim_h;
        longint   bx;
        longint   by;
        longint   bw;
        longint   bh;
        t_det_box b;
        v = value;
        if (elem_count < MAX_ROW) begin
            case (elem_count)
                drd_pkg::POS_CX: row_cx = v;
                drd_pkg::POS_CY: row_cy = v;
                drd_pkg::POS_W:  row_w  = v;
                drd_pkg::POS_H:  row_h  = v;
                default: begin
                    // strict compare keeps the lowest index on ties
                    if (elem_count == drd_pkg::POS_FIRST_SCORE || v > best_score) begin
                        best_score = v;
                        best_class = elem_count - drd_pkg::POS_FIRST_SCORE;
                    end
                end
            endcase
            elem_count++;
        end
        if (last) begin
            if (elem_count > drd_pkg::POS_FIRST_SCORE && best_score >= 0 &&
                best_score >= longint'(thr)) begin
                lim_w = (frame_w > drd_pkg::FRAME_MAX) ? longint'(drd_pkg::FRAME_MAX)
                                                       : longint'(frame_w);
                lim_h = (frame_h > drd_pkg::FRAME_MAX) ? longint'(drd_pkg::FRAME_MAX)
                                                       : longint'(frame_h);
                clamp_span(shr_toward_zero((2 * row_cx - row_w) * longint'(x_scl), FRAC + 13),
                           shr_toward_zero(row_w * longint'(x_scl), FRAC + 12),
                           lim_w, bx, bw);
                clamp_span(shr_toward_zero((2 * row_cy - row_h) * longint'(y_scl), FRAC + 13),
                           shr_toward_zero(row_h * longint'(y_scl), FRAC + 12),
                           lim_h, by, bh);
                b.left      = bx[drd_pkg::EDGE_W-1:0];
                b.top       = by[drd_pkg::EDGE_W-1:0];
                b.width     = bw[drd_pkg::EXT_W-1:0];
                b.height    = bh[drd_pkg::EXT_W-1:0];
                b.class_idx = best_class[drd_pkg::CLASS_W-1:0];
                b.score     = best_score[drd_pkg::SCORE_W-1:0];
                pending_boxes.push_back(b);
            end
            rows_done++;
            clear_row();
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_det_box seen;
        t_det_box want;
        if (!i_rst_n) begin
            thr     = RST_THR;
            x_scl   = RST_SCALE;
            y_scl   = RST_SCALE;
            frame_w = RST_FRAME;
            frame_h = RST_FRAME;
            clear_row();
            pending_boxes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (drd_pkg::t_cfg_index'(i_cfg_index))
                    drd_pkg::CFG_SCORE_THR: thr     = i_cfg_data[drd_pkg::THR_W-1:0];
                    drd_pkg::CFG_X_SCALE:   x_scl   = i_cfg_data[drd_pkg::SCALE_W-1:0];
                    drd_pkg::CFG_Y_SCALE:   y_scl   = i_cfg_data[drd_pkg::SCALE_W-1:0];
                    drd_pkg::CFG_FRAME_W:   frame_w = i_cfg_data[drd_pkg::FRAME_W-1:0];
                    drd_pkg::CFG_FRAME_H:   frame_h = i_cfg_data[drd_pkg::FRAME_W-1:0];
                    default: ;
                endcase
            end
            if (i_box.valid && i_box.ready) begin
                seen = {i_box.box_left, i_box.box_top, i_box.box_width,
                        i_box.box_height, i_box.class_index, i_box.best_score};
                if (pending_boxes.size() == 0) begin
                    note_failure({"box with none expected: ", box_text(seen)});
                end else begin
                    want = pending_boxes.pop_front();
                    if (seen !== want) begin
                        note_failure({"box mismatch: exp ", box_text(want),
                                      " got ", box_text(seen)});
                    end
                end
                boxes_checked++;
            end
            if (i_elem.valid && i_elem.ready) begin
                take_element(i_elem.element_value, i_elem.row_last);
            end
        end
        boxes_pending = pending_boxes.size();
    end

endmodule

/* test/tb_detection_row_decode_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_row_decode_top
// Streams detection rows into the decoder and checks the boxes it returns.
// A short directed set covers short rows, threshold edges, ties and value
// extremes; then random rows run under a series of register settings with
// random gaps and back-pressure. The checker beside the block predicts and
// compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_detection_row_decode_top;

    localparam int MAX_ROW_LENGTH  = 256;
    localparam int VALUE_FRAC_BITS = 12;
    localparam int VALUE_W         = drd_pkg::VALUE_W;

    localparam int          ELEMENT_TARGET = 1350;
    localparam int          ROWS_PER_PHASE = 6;
    localparam int          DRAIN_CYCLES   = 8;         // pipeline is three deep
    localparam int unsigned RUN_LIMIT_NS   = 3_000_000;
    localparam int          RESET_THRESHOLD = 1843;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [drd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [drd_pkg::CFG_W-1:0]     cfg_data;

    drd_in_if  elem_ch ();
    drd_out_if box_ch ();

    int fail_count;
    int boxes_pending;
    int boxes_checked;
    int rows_done;

    // stimulus state
    int elements_sent = 0;
    int reg_writes    = 0;
    int cur_thr       = RESET_THRESHOLD;
    bit in_idle_on    = 1'b0;
    bit out_stall_on  = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    detection_row_decode_top #(
        .MAX_ROW_LENGTH  (MAX_ROW_LENGTH),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_elem      (elem_ch),
        .o_box       (box_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    detection_row_checker #(
        .MAX_ROW (MAX_ROW_LENGTH),
        .FRAC    (VALUE_FRAC_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_elem          (elem_ch),
        .i_box           (box_ch),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_boxes_pending (boxes_pending),
        .o_boxes_checked (boxes_checked),
        .o_rows_done     (rows_done)
    );

    // Idle length: mostly none or short, now and then a long hole.
    function automatic int pick_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // pixels to Q12.12
    function automatic logic signed [VALUE_W-1:0] fx(input int pixels);
        return VALUE_W'(pixels <<< VALUE_FRAC_BITS);
    endfunction

    // Box values: mostly a plausible frame position, some negative, some raw.
    function automatic logic signed [VALUE_W-1:0] pick_box_value(input int pos);
        int unsigned sel;
        int          mag;
        sel = $urandom_range(0, 9);
        if (sel == 0) return VALUE_W'($urandom);
        if (sel == 1) begin
            mag = $urandom_range(0, 100 << VALUE_FRAC_BITS);
            return VALUE_W'(-mag);
        end
        if (pos < drd_pkg::POS_W) mag = $urandom_range(0, 700 << VALUE_FRAC_BITS);
        else mag = $urandom_range(0, 400 << VALUE_FRAC_BITS);
        return VALUE_W'(mag);
    endfunction

    // Scores: around the threshold, ties with the running best, negatives,
    // and the odd full-range value.
    function automatic logic signed [VALUE_W-1:0] pick_score(
        input logic signed [VALUE_W-1:0] best_sofar);
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return VALUE_W'($urandom);
            1:       return VALUE_W'(-int'($urandom_range(1, 4096)));
            2:       return VALUE_W'(cur_thr);
            3:       return VALUE_W'(cur_thr - 1);
            4, 5:    return best_sofar;
            default: return VALUE_W'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic int pick_row_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(1, 4);   // too short for a box
        if (r < 85) return $urandom_range(5, 16);
        return $urandom_range(17, 60);
    endfunction

    // Register values: phases 1..4 pin the corners, later phases roam.
    function automatic int unsigned pick_cfg(input drd_pkg::t_cfg_index idx, input int phase);
        bit is_scale;
        bit is_frame;
        int unsigned sel;
        is_scale = (idx == drd_pkg::CFG_X_SCALE || idx == drd_pkg::CFG_Y_SCALE);
        is_frame = (idx == drd_pkg::CFG_FRAME_W || idx == drd_pkg::CFG_FRAME_H);
        sel      = $urandom_range(0, 5);
        case (phase)
            1: return 0;                                // zero scale and zero frame
            2: return is_scale ? 65535 : 4096;          // top of the normal ranges
            3: begin                                    // frame sizes past 4096
                case (idx)
                    drd_pkg::CFG_SCORE_THR: return 8191;
                    drd_pkg::CFG_FRAME_W:   return 8191;
                    drd_pkg::CFG_FRAME_H:   return 4097;
                    default:                return 1;
                endcase
            end
            4: return is_scale ? 8192 : (is_frame ? 1 : RESET_THRESHOLD);
            default: begin
                if (is_scale) begin
                    if (sel == 0) return 65535;
                    if (sel == 1) return 4096;
                    if (sel == 2) return 0;
                    return $urandom_range(1024, 16384);
                end
                if (is_frame) begin
                    if (sel == 0) return 1;
                    if (sel == 1) return 4096;
                    if (sel == 2) return 640;
                    return $urandom_range(1, 4096);
                end
                if (sel == 0) return 0;
                if (sel == 1) return 4096;
                if (sel == 2) return RESET_THRESHOLD;
                return $urandom_range(0, 4096);
            end
        endcase
    endfunction

    // All tasks below start and end on a falling edge.
    task automatic send_element(input logic signed [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = pick_gap(in_idle_on);
        repeat (gap) begin
            elem_ch.valid <= 1'b0;
            @(negedge clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.element_value <= value;
        elem_ch.row_last      <= last;
        @(posedge clk);
        while (!elem_ch.ready) @(posedge clk);
        @(negedge clk);
        elements_sent++;
    endtask

    task automatic send_list(input logic signed [VALUE_W-1:0] vals[$]);
        foreach (vals[k]) send_element(vals[k], k == vals.size() - 1);
    endtask

    // One random row; about one in ten is pure noise.
    task automatic send_row(input int len);
        bit                          noise;
        logic signed [VALUE_W-1:0]   value;
        logic signed [VALUE_W-1:0]   best_sofar;
        noise      = ($urandom_range(0, 9) == 0);
        best_sofar = '0;
        for (int i = 0; i < len; i++) begin
            if (noise) value = VALUE_W'($urandom);
            else if (i < drd_pkg::POS_FIRST_SCORE) value = pick_box_value(i);
            else value = pick_score(best_sofar);
            if (i == drd_pkg::POS_FIRST_SCORE ||
                (i > drd_pkg::POS_FIRST_SCORE && value > best_sofar))
                best_sofar = value;
            send_element(value, i == len - 1);
        end
    endtask

    // Sender holds off until every box has come out and the pipe is empty.
    task automatic wait_drained();
        elem_ch.valid <= 1'b0;
        while (boxes_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input drd_pkg::t_cfg_index idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[drd_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic retune(input int phase);
        drd_pkg::t_cfg_index regs[5] = '{drd_pkg::CFG_SCORE_THR, drd_pkg::CFG_X_SCALE,
                                         drd_pkg::CFG_Y_SCALE, drd_pkg::CFG_FRAME_W,
                                         drd_pkg::CFG_FRAME_H};
        int unsigned value;
        wait_drained();
        foreach (regs[k]) begin
            if (phase <= 4 || $urandom_range(0, 1) == 1) begin
                value = pick_cfg(regs[k], phase);
                if (regs[k] == drd_pkg::CFG_SCORE_THR) cur_thr = value;
                write_reg(regs[k], value);
            end
        end
    endtask

    // Box side back-pressure, switched on and off per phase.
    initial begin
        int stall_left;
        stall_left   = 0;
        box_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                box_ch.ready <= 1'b0;
            end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(1'b1);
                box_ch.ready <= (stall_left == 0);
            end else begin
                box_ch.ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic signed [VALUE_W-1:0] row_vals[$];
        int                        phase;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = drd_pkg::CFG_SCORE_THR;
        cfg_data              = '0;
        elem_ch.valid         = 1'b0;
        elem_ch.element_value = '0;
        elem_ch.row_last      = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed rows, reset settings, no idling ----
        // single element, then four: both too short for a box
        row_vals = '{fx(10)};
        send_list(row_vals);
        row_vals = '{fx(100), fx(100), fx(20), fx(20)};
        send_list(row_vals);
        // best score exactly at the threshold
        row_vals = '{fx(320), fx(240), fx(100), fx(50), VALUE_W'(RESET_THRESHOLD)};
        send_list(row_vals);
        // value extremes, tied top scores: class 0 must win
        row_vals = '{VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MAX};
        send_list(row_vals);
        // negative best score
        row_vals = '{fx(50), fx(60), fx(30), fx(40), VALUE_W'(-1)};
        send_list(row_vals);
        // one below threshold, box hanging off the frame
        row_vals = '{fx(600), fx(630), fx(200), fx(80), VALUE_W'(RESET_THRESHOLD - 1)};
        send_list(row_vals);

        // ---- random rows across register settings ----
        phase = 1;
        while (elements_sent < ELEMENT_TARGET) begin
            retune(phase);
            in_idle_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            // full-length row, and one running past the limit
            if (phase == 5) send_row(MAX_ROW_LENGTH);
            if (phase == 6) send_row($urandom_range(MAX_ROW_LENGTH + 1, MAX_ROW_LENGTH + 12));
            for (int r = 0; r < ROWS_PER_PHASE; r++) begin
                send_row(pick_row_len());
                if ($urandom_range(0, 15) == 0) wait_drained();
            end
            phase++;
        end

        wait_drained();
        $display("covered %0d elements in %0d rows, %0d boxes checked, %0d register writes",
                 elements_sent, rows_done, boxes_checked, reg_writes);
        $display("settings swept over %0d phases incl. zero/oversize frames and scale limits",
                 phase - 1);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
